// ----- rtl/metaball_field_pixel_shader_core_macros.svh -----
// Assertion macros for the checker file mfps_checker.sv.
`ifndef METABALL_FIELD_PIXEL_SHADER_CORE_MACROS_SVH
`define METABALL_FIELD_PIXEL_SHADER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFPS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfps check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfps check failed");

`endif

// ----- rtl/mfps_pkg.sv -----
package mfps_pkg;

    localparam int NUM_BLOBS = 4;
    localparam int CFG_REG_COUNT = 2 * NUM_BLOBS;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_SEL_W = $clog2(CFG_REG_COUNT);
    localparam int COORD_W = 10;
    localparam int DELTA_W = 12;
    localparam int SQ_W = 22;
    localparam int D2_W = 23;
    localparam int NUM_W = 19;
    localparam int REM_W = 24;
    localparam int QUO_W = NUM_W;
    localparam int DIV_STAGES = NUM_W;
    localparam int SUM_W = QUO_W + 2;
    localparam int FIELD_W = 12;

    localparam logic [D2_W-1:0] DIST_FLOOR = D2_W'(26);
    localparam logic [FIELD_W-1:0] FIELD_MAX = FIELD_W'(4095);
    localparam logic [FIELD_W-1:0] FIELD_ONE = FIELD_W'(256);
    localparam logic [FIELD_W-1:0] FIELD_BLEND_MIN = FIELD_W'(154);
    localparam logic [FIELD_W-1:0] FIELD_CAP = FIELD_W'(640);
    localparam logic [15:0] BLEND_OFFSET = 16'd1536;
    localparam logic [7:0] SAT_BLOB = 8'd240;
    localparam logic [7:0] SAT_BACK = 8'd255;
    localparam logic [7:0] VAL_BACK = 8'd12;
    localparam logic [7:0] VAL_PEAK = 8'd200;
    localparam logic [6:0] VAL_SCALE = 7'd80;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ZONE_BACK,
        ZONE_BLEND,
        ZONE_BLOB
    } zone_t;

    typedef struct packed {
        logic [5:0] pixel_col;
        logic [5:0] pixel_row;
        logic [7:0] blob_hue;
        logic [7:0] back_hue;
    } pixel_in_t;

    typedef struct packed {
        logic [5:0] out_col;
        logic [5:0] out_row;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } pixel_out_t;

    // Squared radius in Q.8, shifted up by eight bits to form the dividend.
    function automatic logic [NUM_W-1:0] blob_dividend(input int unsigned idx);
        case (idx)
            0: return NUM_W'(1239 * 256);
            1: return NUM_W'(2007 * 256);
            2: return NUM_W'(1600 * 256);
            3: return NUM_W'(829 * 256);
            default: return '0;
        endcase
    endfunction

    function automatic coord_t cfg_reset_value(input int unsigned idx);
        case (idx)
            0: return COORD_W'(56);
            2: return COORD_W'(184);
            4: return COORD_W'(120);
            6: return COORD_W'(88);
            default: return COORD_W'(136);
        endcase
    endfunction

endpackage

// ----- rtl/mfps_dist.sv -----
module mfps_dist (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_valid,
    input  mfps_pkg::pixel_in_t      in_item,
    input  mfps_pkg::coord_t         centre_x [mfps_pkg::NUM_BLOBS],
    input  mfps_pkg::coord_t         centre_y [mfps_pkg::NUM_BLOBS],
    output logic                     d2_valid,
    output mfps_pkg::pixel_in_t      d2_item,
    output logic [mfps_pkg::D2_W-1:0] d2 [mfps_pkg::NUM_BLOBS]
);
    import mfps_pkg::*;

    logic                      sq_valid_reg;
    pixel_in_t                 sq_item_reg;
    logic [SQ_W-1:0]           sqx_reg [NUM_BLOBS];
    logic [SQ_W-1:0]           sqy_reg [NUM_BLOBS];
    logic [SQ_W-1:0]           sqx_next [NUM_BLOBS];
    logic [SQ_W-1:0]           sqy_next [NUM_BLOBS];
    logic                      d2_valid_reg;
    pixel_in_t                 d2_item_reg;
    logic [D2_W-1:0]           d2_reg [NUM_BLOBS];
    logic [D2_W-1:0]           d2_next [NUM_BLOBS];

    always_comb
    begin
        logic signed [DELTA_W-1:0] px;
        logic signed [DELTA_W-1:0] py;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [2*DELTA_W-1:0] mx;
        logic signed [2*DELTA_W-1:0] my;
        px = $signed({2'b00, in_item.pixel_col, 4'b0000});
        py = $signed({2'b00, in_item.pixel_row, 4'b0000});
        for (int i = 0; i < NUM_BLOBS; i++)
        begin
            dx = px - DELTA_W'(centre_x[i]);
            dy = py - DELTA_W'(centre_y[i]);
            mx = dx * dx;
            my = dy * dy;
            sqx_next[i] = mx[SQ_W-1:0];
            sqy_next[i] = my[SQ_W-1:0];
        end
    end

    always_comb
    begin
        logic [D2_W-1:0] sum;
        for (int i = 0; i < NUM_BLOBS; i++)
        begin
            sum = D2_W'(sqx_reg[i]) + D2_W'(sqy_reg[i]);
            d2_next[i] = (sum < DIST_FLOOR) ? DIST_FLOOR : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sq_valid_reg <= in_valid;
            d2_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_item_reg <= in_item;
            d2_item_reg <= sq_item_reg;
            for (int i = 0; i < NUM_BLOBS; i++)
            begin
                sqx_reg[i] <= sqx_next[i];
                sqy_reg[i] <= sqy_next[i];
                d2_reg[i] <= d2_next[i];
            end
        end
    end

    assign d2_valid = d2_valid_reg;
    assign d2_item = d2_item_reg;
    assign d2 = d2_reg;

endmodule

// ----- rtl/mfps_div.sv -----
module mfps_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      in_valid,
    input  mfps_pkg::pixel_in_t       in_item,
    input  logic [mfps_pkg::D2_W-1:0] d2 [mfps_pkg::NUM_BLOBS],
    output logic                      q_valid,
    output mfps_pkg::pixel_in_t       q_item,
    output logic [mfps_pkg::QUO_W-1:0] quo [mfps_pkg::NUM_BLOBS]
);
    import mfps_pkg::*;

    logic              vld_reg  [DIV_STAGES];
    pixel_in_t         item_reg [DIV_STAGES];
    logic [D2_W-1:0]   dvs_reg  [DIV_STAGES][NUM_BLOBS];
    logic [REM_W-1:0]  rem_reg  [DIV_STAGES][NUM_BLOBS];
    logic [QUO_W-1:0]  quo_reg  [DIV_STAGES][NUM_BLOBS];
    logic [REM_W-1:0]  rem_next [DIV_STAGES][NUM_BLOBS];
    logic [QUO_W-1:0]  quo_next [DIV_STAGES][NUM_BLOBS];

    // One quotient bit per stage, dividend bits shifted in from the top.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        always_comb
        begin
            logic [REM_W-1:0] rem_in;
            logic [QUO_W-1:0] quo_in;
            logic [D2_W-1:0]  dvs;
            logic [NUM_W-1:0] dividend;
            logic [REM_W-1:0] trial;
            for (int i = 0; i < NUM_BLOBS; i++)
            begin
                dividend = blob_dividend(i);
                if (k == 0)
                begin
                    rem_in = '0;
                    quo_in = '0;
                    dvs = d2[i];
                end
                else
                begin
                    rem_in = rem_reg[(k == 0) ? 0 : k-1][i];
                    quo_in = quo_reg[(k == 0) ? 0 : k-1][i];
                    dvs = dvs_reg[(k == 0) ? 0 : k-1][i];
                end
                trial = {rem_in[REM_W-2:0], dividend[NUM_W-1-k]};
                if (trial >= REM_W'(dvs))
                begin
                    rem_next[k][i] = trial - REM_W'(dvs);
                    quo_next[k][i] = {quo_in[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = trial;
                    quo_next[k][i] = {quo_in[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                item_reg[k] <= (k == 0) ? in_item : item_reg[(k == 0) ? 0 : k-1];
                for (int i = 0; i < NUM_BLOBS; i++)
                begin
                    dvs_reg[k][i] <= (k == 0) ? d2[i] : dvs_reg[(k == 0) ? 0 : k-1][i];
                    rem_reg[k][i] <= rem_next[k][i];
                    quo_reg[k][i] <= quo_next[k][i];
                end
            end
        end
    end

    assign q_valid = vld_reg[DIV_STAGES-1];
    assign q_item = item_reg[DIV_STAGES-1];
    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// ----- rtl/mfps_shade.sv -----
module mfps_shade (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  mfps_pkg::pixel_in_t        in_item,
    input  logic [mfps_pkg::QUO_W-1:0] quo [mfps_pkg::NUM_BLOBS],
    output logic                       out_valid,
    output mfps_pkg::pixel_out_t       out_item
);
    import mfps_pkg::*;

    logic               fld_valid_reg;
    pixel_in_t          fld_item_reg;
    logic [FIELD_W-1:0] field_reg;
    logic [FIELD_W-1:0] field_next;
    logic               zn_valid_reg;
    pixel_in_t          zn_item_reg;
    zone_t              zone_reg;
    zone_t              zone_next;
    logic [7:0]         factor_reg;
    logic [7:0]         factor_next;
    logic [7:0]         vblob_reg;
    logic [7:0]         vblob_next;
    logic               out_valid_reg;
    pixel_out_t         out_item_reg;
    pixel_out_t         out_item_next;

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < NUM_BLOBS; i++)
        begin
            sum = sum + SUM_W'(quo[i]);
        end
        field_next = (sum > SUM_W'(FIELD_MAX)) ? FIELD_MAX : sum[FIELD_W-1:0];
    end

    always_comb
    begin
        logic [15:0] ten_s;
        logic [15:0] offs;
        logic [17:0] prod;
        logic [9:0]  capped;
        logic [15:0] scaled;
        ten_s = {1'b0, field_reg, 3'b000} + {3'b000, field_reg, 1'b0};
        offs = ten_s - BLEND_OFFSET;
        prod = 18'(offs[10:0]) * 18'd255;
        factor_next = prod[17:10];
        capped = (field_reg < FIELD_CAP) ? field_reg[9:0] : FIELD_CAP[9:0];
        scaled = 16'(capped) * 16'(VAL_SCALE);
        vblob_next = scaled[15:8];
        if (field_reg > FIELD_ONE)
        begin
            zone_next = ZONE_BLOB;
        end
        else if (field_reg >= FIELD_BLEND_MIN)
        begin
            zone_next = ZONE_BLEND;
        end
        else
        begin
            zone_next = ZONE_BACK;
        end
    end

    always_comb
    begin
        logic [8:0]  step;
        logic [7:0]  diff;
        logic [16:0] hmul;
        logic [16:0] vmul;
        logic [7:0]  hmix;
        logic [7:0]  vmix;
        step = {1'b0, factor_reg} + 9'd1;
        if (zn_item_reg.blob_hue > zn_item_reg.back_hue)
        begin
            diff = zn_item_reg.blob_hue - zn_item_reg.back_hue;
            hmul = 17'(diff) * 17'(step);
            hmix = zn_item_reg.back_hue + hmul[15:8];
        end
        else
        begin
            diff = zn_item_reg.back_hue - zn_item_reg.blob_hue;
            hmul = 17'(diff) * 17'(step);
            hmix = zn_item_reg.back_hue - hmul[15:8];
        end
        vmul = 17'(VAL_PEAK - VAL_BACK) * 17'(step);
        vmix = VAL_BACK + vmul[15:8];
        out_item_next.out_col = zn_item_reg.pixel_col;
        out_item_next.out_row = zn_item_reg.pixel_row;
        case (zone_reg)
            ZONE_BLOB:
            begin
                out_item_next.hue = zn_item_reg.blob_hue;
                out_item_next.saturation = SAT_BLOB;
                out_item_next.brightness = vblob_reg;
            end
            ZONE_BLEND:
            begin
                out_item_next.hue = hmix;
                out_item_next.saturation = SAT_BLOB;
                out_item_next.brightness = vmix;
            end
            default:
            begin
                out_item_next.hue = zn_item_reg.back_hue;
                out_item_next.saturation = SAT_BACK;
                out_item_next.brightness = VAL_BACK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_valid_reg <= 1'b0;
            zn_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fld_valid_reg <= in_valid;
            zn_valid_reg <= fld_valid_reg;
            out_valid_reg <= zn_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fld_item_reg <= in_item;
            field_reg <= field_next;
            zn_item_reg <= fld_item_reg;
            zone_reg <= zone_next;
            factor_reg <= factor_next;
            vblob_reg <= vblob_next;
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

endmodule

// ----- rtl/metaball_field_pixel_shader_core.sv -----
// Shades one pixel per clock from a metaball field of four blobs whose centres are set
// through the configuration port; an item is accepted every cycle the output is free or
// being taken, and its result passes through registered distance math, the per-blob
// pipelined divider that yields one quotient bit per stage, and field summing and
// shading, with the final stage as the output register.
module metaball_field_pixel_shader_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mfps_pkg::pixel_in_t             in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mfps_pkg::pixel_out_t            out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  mfps_pkg::coord_t                cfg_data
);
    import mfps_pkg::*;

    coord_t           cfg_reg [CFG_REG_COUNT];
    coord_t           centre_x [NUM_BLOBS];
    coord_t           centre_y [NUM_BLOBS];
    logic             advance;
    logic             d2_valid;
    pixel_in_t        d2_item;
    logic [D2_W-1:0]  d2 [NUM_BLOBS];
    logic             q_valid;
    pixel_in_t        q_item;
    logic [QUO_W-1:0] quo [NUM_BLOBS];

    assign advance = !out_valid || out_ready;
    assign in_ready = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REG_COUNT; i++)
            begin
                cfg_reg[i] <= cfg_reset_value(i);
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(CFG_REG_COUNT)))
        begin
            cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BLOBS; i++)
        begin
            centre_x[i] = cfg_reg[2*i];
            centre_y[i] = cfg_reg[2*i+1];
        end
    end

    mfps_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item),
        .centre_x (centre_x),
        .centre_y (centre_y),
        .d2_valid (d2_valid),
        .d2_item  (d2_item),
        .d2       (d2)
    );

    mfps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (d2_valid),
        .in_item  (d2_item),
        .d2       (d2),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .quo      (quo)
    );

    mfps_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .quo       (quo),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

// ----- rtl/mfps_checker.sv -----
`include "metaball_field_pixel_shader_core_macros.svh"

module mfps_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  mfps_pkg::pixel_out_t out_item
);
    import mfps_pkg::*;

    `MFPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `MFPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item))
    `MFPS_ASSERT_SAME(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready))
    `MFPS_ASSERT_SAME(a_back_color, out_valid && (out_item.saturation != SAT_BLOB),
        (out_item.saturation == SAT_BACK) && (out_item.brightness == VAL_BACK))

endmodule

bind metaball_field_pixel_shader_core mfps_checker u_mfps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mfps_pkg::*;

    localparam int LATENCY = 24;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    pixel_in_t in_item;
    logic out_valid;
    logic out_ready;
    pixel_out_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    coord_t cfg_data;

    coord_t centre [CFG_REG_COUNT];
    pixel_out_t shade_queue [$];
    int error_count;
    longint cycle_count;
    bit hold_long;

    metaball_field_pixel_shader_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int unsigned blob_radius_sq(input int b);
        case (b)
            0: return 1239;
            1: return 2007;
            2: return 1600;
            default: return 829;
        endcase
    endfunction

    function automatic int unsigned mix8(input int unsigned a, input int unsigned b,
                                         input int unsigned f);
        if (b > a)
            return a + (((b - a) * (f + 1)) >> 8);
        return a - (((a - b) * (f + 1)) >> 8);
    endfunction

    function automatic pixel_out_t shade_pixel(input pixel_in_t p);
        pixel_out_t r;
        int dx;
        int dy;
        longint unsigned d2;
        longint unsigned field;
        int unsigned f;
        int unsigned c;
        field = 0;
        for (int b = 0; b < NUM_BLOBS; b++)
        begin
            dx = int'(p.pixel_col) * 16 - int'(centre[2 * b]);
            dy = int'(p.pixel_row) * 16 - int'(centre[2 * b + 1]);
            d2 = longint'(dx * dx + dy * dy);
            if (d2 < 26)
                d2 = 26;
            field += (longint'(blob_radius_sq(b)) << 8) / d2;
        end
        if (field > 4095)
            field = 4095;
        r.out_col = p.pixel_col;
        r.out_row = p.pixel_row;
        if (field > 256)
        begin
            c = (field < 640) ? int'(field) : 640;
            r.hue = p.blob_hue;
            r.saturation = SAT_BLOB;
            r.brightness = 8'((80 * c) >> 8);
        end
        else if (field >= 154)
        begin
            f = ((10 * int'(field) - 1536) * 255) >> 10;
            r.hue = 8'(mix8(p.back_hue, p.blob_hue, f));
            r.saturation = SAT_BLOB;
            r.brightness = 8'(mix8(VAL_BACK, VAL_PEAK, f));
        end
        else
        begin
            r.hue = p.back_hue;
            r.saturation = SAT_BACK;
            r.brightness = VAL_BACK;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input pixel_in_t p);
        in_valid <= 1'b1;
        in_item <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shade_queue.push_back(shade_pixel(p));
    endtask

    task automatic send_gapped(input pixel_in_t p, input bit gaps);
        int unsigned g;
        g = gaps ? pick_gap() : 0;
        cfg_valid <= 1'b0;
        if (g != 0)
            in_valid <= 1'b0;
        repeat (g) @(posedge clk);
        send_pixel(p);
    endtask

    task automatic write_centre(input int idx, input coord_t v);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < CFG_REG_COUNT)
            centre[idx] = v;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (shade_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        p = pixel_in_t'($urandom);
        return p;
    endfunction

    task automatic test_directed();
        pixel_in_t p;
        int xs [5] = '{0, 63, 3, 11, 5};
        int ys [5] = '{0, 63, 8, 8, 9};
        for (int i = 0; i < 5; i++)
        begin
            p.pixel_col = 6'(xs[i]);
            p.pixel_row = 6'(ys[i]);
            p.blob_hue = (i % 2) ? 8'hFF : 8'h00;
            p.back_hue = (i % 2) ? 8'h00 : 8'hFF;
            send_gapped(p, 1'b0);
        end
        // Sweep near the default centres to pass through blend and core zones.
        for (int i = 0; i < 16; i++)
        begin
            p.pixel_col = 6'(i);
            p.pixel_row = 6'(8 + (i % 3));
            p.blob_hue = 8'($urandom);
            p.back_hue = 8'($urandom);
            send_gapped(p, 1'b1);
        end
        drain();
        // A pixel exactly on a centre hits the distance floor and saturates the field.
        for (int b = 0; b < CFG_REG_COUNT; b++)
            write_centre(b, coord_t'(160));
        write_centre(CFG_REG_COUNT + 3, coord_t'(-512));
        p.pixel_col = 6'd10;
        p.pixel_row = 6'd10;
        p.blob_hue = 8'h5A;
        p.back_hue = 8'hA5;
        send_gapped(p, 1'b0);
        p.pixel_col = 6'd63;
        send_gapped(p, 1'b0);
        drain();
    endtask

    task automatic test_random_configs();
        int sets;
        sets = 8;
        for (int s = 0; s < sets; s++)
        begin
            for (int b = 0; b < CFG_REG_COUNT; b++)
            begin
                case (s)
                    0: write_centre(b, coord_t'(-512));
                    1: write_centre(b, coord_t'(511));
                    2: write_centre(b, coord_t'(0));
                    default: write_centre(b, coord_t'($urandom_range(0, 1023)));
                endcase
            end
            if ($urandom_range(0, 1))
                write_centre($urandom_range(CFG_REG_COUNT, 15), coord_t'($urandom));
            for (int i = 0; i < 170; i++)
                send_gapped(random_pixel(), (i % 60) > 20);
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_long = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pixel(random_pixel());
        drain();
        for (int b = 0; b < CFG_REG_COUNT; b++)
            write_centre(b, cfg_reset_value(b));
        for (int i = 0; i < 40; i++)
            send_gapped(random_pixel(), 1'b1);
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin : out_stall
            int unsigned k;
            k = $urandom_range(0, 99);
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_long = 1'b0;
                out_ready <= 1'b1;
            end
            else if (k < 70)
                out_ready <= 1'b1;
            else if (k < 97)
                out_ready <= 1'b0;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 50)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (shade_queue.size() == 0)
            begin
                $error("unexpected item: %h", out_item);
                error_count++;
            end
            else
            begin : compare
                pixel_out_t e;
                e = shade_queue.pop_front();
                if (out_item.out_col !== e.out_col)
                begin
                    $error("out_col expected %0d actual %0d", e.out_col, out_item.out_col);
                    error_count++;
                end
                if (out_item.out_row !== e.out_row)
                begin
                    $error("out_row expected %0d actual %0d", e.out_row, out_item.out_row);
                    error_count++;
                end
                if (out_item.hue !== e.hue)
                begin
                    $error("hue expected %0d actual %0d", e.hue, out_item.hue);
                    error_count++;
                end
                if (out_item.saturation !== e.saturation)
                begin
                    $error("saturation expected %0d actual %0d", e.saturation,
                           out_item.saturation);
                    error_count++;
                end
                if (out_item.brightness !== e.brightness)
                begin
                    $error("brightness expected %0d actual %0d", e.brightness,
                           out_item.brightness);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        hold_long = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int b = 0; b < CFG_REG_COUNT; b++)
            centre[b] = cfg_reset_value(b);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_configs();
        test_backpressure();
        if (error_count == 0 && shade_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
